// File: src/fxdf_pkg.sv
// Shared types and constants for the frequency-translating decimating FIR.
// Used by fxdf_cmul and freq_xlating_decimating_fir_core; no dependencies.
package fxdf_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int PROD_W       = 2 * SAMPLE_W + 1;   // ar*br - ai*bi
    localparam int TAP_IDX_W    = 6;
    localparam int DEC_W        = 7;
    localparam int DEC_MAX      = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 72;
    localparam int OUT_TDATA_W  = 32;
    localparam int DEF_NUM_TAPS = 64;
    localparam int RND_HALF     = 16384;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP_RE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP_IM = 2'd2;

    // command carried in tuser
    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_TAP_WRITE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_ROT,
        S_PHS,
        S_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic valid;   // result registers hold a new product
        logic busy;    // a product is somewhere in the pipe
    } t_mul_stat;

endpackage

// File: src/fxdf_cmul.sv
// Shared complex multiplier: two register stages (products, then sums).
// Depends on fxdf_pkg.
module fxdf_cmul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [fxdf_pkg::SAMPLE_W-1:0] i_a_re,
    input  logic signed [fxdf_pkg::SAMPLE_W-1:0] i_a_im,
    input  logic signed [fxdf_pkg::SAMPLE_W-1:0] i_b_re,
    input  logic signed [fxdf_pkg::SAMPLE_W-1:0] i_b_im,
    output logic signed [fxdf_pkg::PROD_W-1:0]   o_re,
    output logic signed [fxdf_pkg::PROD_W-1:0]   o_im,
    output fxdf_pkg::t_mul_stat                  o_stat
);
    import fxdf_pkg::*;

    logic                              r_vld1;
    logic                              r_vld2;
    logic signed [2*SAMPLE_W-1:0]      r_p_rr;
    logic signed [2*SAMPLE_W-1:0]      r_p_ii;
    logic signed [2*SAMPLE_W-1:0]      r_p_ri;
    logic signed [2*SAMPLE_W-1:0]      r_p_ir;
    logic signed [PROD_W-1:0]          r_re;
    logic signed [PROD_W-1:0]          r_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_rr <= i_a_re * i_b_re;
        r_p_ii <= i_a_im * i_b_im;
        r_p_ri <= i_a_re * i_b_im;
        r_p_ir <= i_a_im * i_b_re;
        r_re   <= PROD_W'(r_p_rr) - PROD_W'(r_p_ii);
        r_im   <= PROD_W'(r_p_ri) + PROD_W'(r_p_ir);
    end

    assign o_re        = r_re;
    assign o_im        = r_im;
    assign o_stat.valid = r_vld2;
    assign o_stat.busy  = r_vld1 | r_vld2;

endmodule

// File: src/freq_xlating_decimating_fir_core.sv
// Top level of the frequency-translating decimating FIR: sequencer, delay line,
// tap store, accumulator and phasor around one shared complex multiplier.
// Depends on fxdf_pkg and fxdf_cmul.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tuser command, tdata sample/tap
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata out_re, out_im
//  cfg      | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Tap writes and samples that start no decimation group leave the sequencer idle.
// A sample that starts a decimation group sets off the filter run: the
// shared complex multiplier walks the taps one per cycle, then does the rotation
// and the phasor update. s_axis_tready stays low until the result is loaded.
// The result sits in an output register; a stalled m_axis holds only the final step.
// Reset is synchronous, active low; the delay line is not reset, entries past the fill count read as zero.
module freq_xlating_decimating_fir_core #(
    parameter int NUM_TAPS = fxdf_pkg::DEF_NUM_TAPS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] sample_re, [31:16] sample_im, [37:32] tap_index,
    // [53:38] tap_re, [69:54] tap_im, [71:70] zero
    input  logic [fxdf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // [0] command
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [15:0] out_re, [31:16] out_im
    output logic [fxdf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fxdf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fxdf_pkg::SAMPLE_W-1:0]         i_cfg_data
);
    import fxdf_pkg::*;

    localparam int AW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int FILLW = $clog2(NUM_TAPS + 1);
    localparam int ACCW  = PROD_W + $clog2(NUM_TAPS);
    localparam int QW    = ACCW + 1 - 15;

    t_state                      r_state, n_state;

    // configuration
    logic [DEC_W-1:0]            r_decimation;
    logic signed [SAMPLE_W-1:0]  r_step_re;
    logic signed [SAMPLE_W-1:0]  r_step_im;

    // stores
    logic [2*SAMPLE_W-1:0]       line_mem [NUM_TAPS];
    logic [2*SAMPLE_W-1:0]       tap_mem  [NUM_TAPS];
    logic [2*SAMPLE_W-1:0]       r_line_q;
    logic [2*SAMPLE_W-1:0]       r_tap_q;

    logic [AW-1:0]               r_wp;
    logic [AW-1:0]               r_ra;
    logic [AW-1:0]               r_k;
    logic [FILLW-1:0]            r_fill;
    logic [TAP_IDX_W-1:0]        r_group;
    logic                        r_rd_vld;
    logic                        r_rd_live;

    logic signed [ACCW-1:0]      r_acc_re;
    logic signed [ACCW-1:0]      r_acc_im;
    logic signed [SAMPLE_W-1:0]  r_phasor_re;
    logic signed [SAMPLE_W-1:0]  r_phasor_im;
    logic signed [SAMPLE_W-1:0]  r_y_re;
    logic signed [SAMPLE_W-1:0]  r_y_im;
    logic                        r_got_rot;

    logic                        r_m_valid;
    logic [OUT_TDATA_W-1:0]      r_m_data;

    // input fields
    logic signed [SAMPLE_W-1:0]  in_sample_re, in_sample_im, in_tap_re, in_tap_im;
    logic [TAP_IDX_W-1:0]        in_tap_index;
    logic                        in_accept;
    logic                        accept_sample;
    logic                        accept_tap;

    logic [AW-1:0]               wp_next;
    logic [DEC_W-1:0]            dec_eff;
    logic [DEC_W-1:0]            group_inc;
    logic                        fires;
    logic                        k_last;

    // multiplier
    logic                        mul_in_vld;
    logic signed [SAMPLE_W-1:0]  mul_a_re, mul_a_im, mul_b_re, mul_b_im;
    logic signed [PROD_W-1:0]    mul_re, mul_im;
    t_mul_stat                   mul_stat;
    logic signed [SAMPLE_W-1:0]  s_re, s_im, m_re, m_im;
    logic                        out_load;

    // Q.30 to Q1.15: add half, floor shift, saturate
    function automatic logic signed [SAMPLE_W-1:0] f_round_sat(
        input logic signed [ACCW-1:0] x
    );
        logic signed [ACCW:0]   y;
        logic signed [QW-1:0]   q;
        logic signed [SAMPLE_W-1:0] r;
        y = $signed({x[ACCW-1], x}) + (ACCW+1)'(RND_HALF);
        q = $signed(y[ACCW:15]);
        if (q > QW'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (q < QW'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    assign in_sample_re = s_axis_tdata[15:0];
    assign in_sample_im = s_axis_tdata[31:16];
    assign in_tap_index = s_axis_tdata[37:32];
    assign in_tap_re    = s_axis_tdata[53:38];
    assign in_tap_im    = s_axis_tdata[69:54];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign accept_sample = in_accept & (s_axis_tuser == CMD_SAMPLE);
    assign accept_tap    = in_accept & (s_axis_tuser == CMD_TAP_WRITE);

    assign wp_next = (r_wp == AW'(NUM_TAPS - 1)) ? '0 : r_wp + 1'b1;
    assign k_last  = (r_k == AW'(NUM_TAPS - 1));

    always_comb begin
        if (r_decimation == '0) begin
            dec_eff = DEC_W'(1);
        end else if (r_decimation > DEC_W'(DEC_MAX)) begin
            dec_eff = DEC_W'(DEC_MAX);
        end else begin
            dec_eff = r_decimation;
        end
    end
    assign group_inc = DEC_W'(r_group) + 1'b1;
    assign fires     = (r_group == '0);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign out_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept_sample && fires) n_state = S_MAC;
            end
            S_MAC: begin
                if (k_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_rd_vld && !mul_stat.busy) n_state = S_ROT;
            end
            S_ROT:  n_state = S_PHS;
            S_PHS:  n_state = S_WAIT;
            S_WAIT: begin
                if (mul_stat.valid && r_got_rot) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration port: writes land only between input transactions
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decimation <= DEC_W'(1);
            r_step_re    <= SAT_MAX;
            r_step_im    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DECIMATION:    r_decimation <= i_cfg_data[DEC_W-1:0];
                CFG_PHASE_STEP_RE: r_step_re    <= i_cfg_data;
                CFG_PHASE_STEP_IM: r_step_im    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (accept_sample) begin
            line_mem[wp_next] <= {in_sample_im, in_sample_re};
        end
        if (accept_tap && (int'(in_tap_index) < NUM_TAPS)) begin
            tap_mem[AW'(in_tap_index)] <= {in_tap_im, in_tap_re};
        end
        r_line_q <= line_mem[r_ra];
        r_tap_q  <= tap_mem[r_k];
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_fill    <= '0;
            r_group   <= '0;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_got_rot <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_MAC);
            if (accept_sample) begin
                r_wp <= wp_next;
                if (r_fill != FILLW'(NUM_TAPS)) r_fill <= r_fill + 1'b1;
                if (!fires) begin
                    r_group <= (group_inc >= dec_eff) ? '0 : group_inc[TAP_IDX_W-1:0];
                end else begin
                    r_group <= (dec_eff > DEC_W'(1)) ? TAP_IDX_W'(1) : '0;
                end
            end
            if (r_state == S_MAC) begin
                r_k <= k_last ? '0 : r_k + 1'b1;
            end
            if (r_state == S_ROT) begin
                r_got_rot <= 1'b0;
            end else if (r_state == S_WAIT && mul_stat.valid) begin
                r_got_rot <= 1'b1;
            end
        end
    end

    // line read pointer walks from newest to oldest
    always_ff @(posedge i_clk) begin
        if (accept_sample) begin
            r_ra <= wp_next;
        end else if (r_state == S_MAC) begin
            r_ra <= (r_ra == '0) ? AW'(NUM_TAPS - 1) : r_ra - 1'b1;
        end
        r_rd_live <= (FILLW'(r_k) < r_fill);
    end

    // shared multiplier operand select
    assign s_re = f_round_sat(r_acc_re);
    assign s_im = f_round_sat(r_acc_im);

    always_comb begin
        mul_in_vld = 1'b0;
        mul_a_re   = r_tap_q[SAMPLE_W-1:0];
        mul_a_im   = r_tap_q[2*SAMPLE_W-1:SAMPLE_W];
        mul_b_re   = r_rd_live ? r_line_q[SAMPLE_W-1:0] : '0;
        mul_b_im   = r_rd_live ? r_line_q[2*SAMPLE_W-1:SAMPLE_W] : '0;
        if (r_rd_vld) begin
            mul_in_vld = 1'b1;
        end else if (r_state == S_ROT) begin
            mul_in_vld = 1'b1;
            mul_a_re   = s_re;
            mul_a_im   = s_im;
            mul_b_re   = r_phasor_re;
            mul_b_im   = r_phasor_im;
        end else if (r_state == S_PHS) begin
            mul_in_vld = 1'b1;
            mul_a_re   = r_phasor_re;
            mul_a_im   = r_phasor_im;
            mul_b_re   = r_step_re;
            mul_b_im   = r_step_im;
        end
    end

    fxdf_cmul u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_in_vld),
        .i_a_re  (mul_a_re),
        .i_a_im  (mul_a_im),
        .i_b_re  (mul_b_re),
        .i_b_im  (mul_b_im),
        .o_re    (mul_re),
        .o_im    (mul_im),
        .o_stat  (mul_stat)
    );

    assign m_re = f_round_sat(ACCW'(mul_re));
    assign m_im = f_round_sat(ACCW'(mul_im));

    // accumulator
    always_ff @(posedge i_clk) begin
        if (accept_sample && fires) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (mul_stat.valid && (r_state == S_MAC || r_state == S_DRAIN)) begin
            r_acc_re <= r_acc_re + ACCW'(mul_re);
            r_acc_im <= r_acc_im + ACCW'(mul_im);
        end
    end

    // rotation result and phasor update, in issue order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phasor_re <= SAT_MAX;
            r_phasor_im <= '0;
        end else if (r_state == S_WAIT && mul_stat.valid && r_got_rot) begin
            r_phasor_re <= m_re;
            r_phasor_im <= m_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && mul_stat.valid && !r_got_rot) begin
            r_y_re <= m_re;
            r_y_im <= m_im;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {r_y_im, r_y_re};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // checks
    a_ready_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !mul_stat.busy)
        else $error("input accepted while the multiplier is busy");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILLW'(NUM_TAPS))
        else $error("fill count beyond delay line depth");

    a_mul_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_stat.valid |-> (r_state == S_MAC || r_state == S_DRAIN || r_state == S_WAIT))
        else $error("multiplier result arrived in no consuming state");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_m_valid || m_axis_tready))
        else $error("output register overwritten before its transaction");

endmodule
